// ===== rtl/core/pme_pkg.sv =====
package pme_pkg;

  localparam int PME_MAX_GENES  = 64;
  localparam int PME_GENE_WIDTH = 16;

  localparam int OPCODE_W      = 3;
  localparam int POSITION_W    = 6;
  localparam int GENE_VALUE_W  = 16;
  localparam int READ_VALUE_W  = 16;
  localparam int GENE_COUNT_W  = 7;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 24;

  localparam logic [GENE_COUNT_W-1:0] GENE_COUNT_RESET = 7'd64;

  localparam logic [OPCODE_W-1:0] OP_WRITE      = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_READ       = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SWAP       = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_INSERT     = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_INVERSION  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_MOVE_RANGE = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_ROTATE     = 3'd6;

  // one decoded item together with the gene count in force when it arrived
  typedef struct packed {
    logic [OPCODE_W-1:0]     op;
    logic [POSITION_W-1:0]   first;
    logic [POSITION_W-1:0]   second;
    logic [POSITION_W-1:0]   run_len;
    logic [GENE_COUNT_W-1:0] count;
  } pme_cmd_t;

endpackage

// ===== rtl/core/pme_ram.sv =====
module pme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pme_map.sv =====
module pme_map #(
  parameter int MAX_GENES = 64
) (
  input  pme_pkg::pme_cmd_t               cmd,
  input  logic [$clog2(MAX_GENES)-1:0]    idx,
  output logic [$clog2(MAX_GENES)-1:0]    src,
  output logic                            ok
);

  import pme_pkg::*;

  localparam int AW = $clog2(MAX_GENES);
  localparam int CW = (AW + 2 > 8) ? AW + 2 : 8;

  logic [CW-1:0] n, i, f, t, len, lo, hi, j, s;
  logic          count_ok, pos_ok;

  // validity of the operands
  always_comb begin
    n   = CW'(cmd.count);
    f   = CW'(cmd.first);
    t   = CW'(cmd.second);
    len = CW'(cmd.run_len);
    count_ok = (n >= CW'(2)) && (n <= CW'(MAX_GENES));
    pos_ok   = (f < n) && (t < n);
    case (cmd.op)
      OP_WRITE, OP_READ, OP_ROTATE: ok = count_ok && (f < n);
      OP_SWAP, OP_INSERT, OP_INVERSION: ok = count_ok && pos_ok;
      OP_MOVE_RANGE: ok = count_ok && (len != '0) && (len < n)
                          && (f + len <= n) && (t + len <= n);
      default: ok = 1'b0;
    endcase
  end

  // source position of the gene that lands at idx; entries at or above the count stay put
  always_comb begin
    i  = CW'(idx);
    lo = (f < t) ? f : t;
    hi = (f < t) ? t : f;
    j  = '0;
    s  = i;
    if (i < n) begin
      case (cmd.op)
        OP_SWAP: begin
          if (i == f) begin
            s = t;
          end else if (i == t) begin
            s = f;
          end
        end
        OP_INSERT: begin
          if (f < t) begin
            if (i >= f && i < t) begin
              s = i + CW'(1);
            end else if (i == t) begin
              s = f;
            end
          end else if (f > t) begin
            if (i == t) begin
              s = f;
            end else if (i > t && i <= f) begin
              s = i - CW'(1);
            end
          end
        end
        OP_INVERSION: begin
          if (i >= lo && i < hi) begin
            s = lo + hi - CW'(1) - i;
          end
        end
        OP_MOVE_RANGE: begin
          if (i >= t && i < t + len) begin
            s = f + i - t;
          end else begin
            // index into the genes left after the run is taken out
            j = (i < t) ? i : i - len;
            s = (j < f) ? j : j + len;
          end
        end
        OP_ROTATE: begin
          j = i + f;
          s = (j >= n) ? j - n : j;
        end
        default: s = i;
      endcase
    end
    src = AW'(s);
  end

endmodule

// ===== rtl/core/permutation_mutation_engine.sv =====
// channel  direction  width  fields, lowest bit first
// s_*      in         40     opcode[2:0] first_position[8:3] second_position[14:9]
//                            run_length[20:15] gene_value[36:21]
// m_*      out        24     read_value[15:0] status[16]
// cfg_*    in         7      gene_count
// Write and rejected items go from accept through DECODE to FIN; reads also pass READ.
// Permuting items go through DECODE, a copy pass and FIN: the pass copies every
// entry of the active bank through the position map into the other bank, one entry
// per cycle on the single RAM read port, then the banks swap roles.
// Reset is synchronous; it clears control state only, the gene banks hold garbage.
// A stalled result holds in the output register while the next item is accepted.
module permutation_mutation_engine #(
  parameter int MAX_GENES  = pme_pkg::PME_MAX_GENES,
  parameter int GENE_WIDTH = pme_pkg::PME_GENE_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [pme_pkg::GENE_COUNT_W-1:0]   cfg_wr_data,   // gene_count
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [pme_pkg::IN_TDATA_W-1:0]     s_tdata,       // opcode, first_position,
                                                            // second_position, run_length,
                                                            // gene_value
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [pme_pkg::OUT_TDATA_W-1:0]    m_tdata        // read_value, status
);

  import pme_pkg::*;

  localparam int AW = $clog2(MAX_GENES);
  localparam logic [AW:0] LAST = (AW + 1)'(MAX_GENES);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_READ   = 5'b00100,
    S_COPY   = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t                   state;
  pme_cmd_t                 cmd;
  logic [GENE_WIDTH-1:0]    gene;
  logic [GENE_COUNT_W-1:0]  gene_count;
  logic                     bank;
  logic [AW:0]              cnt;
  logic                     wr_pend;
  logic [AW-1:0]            wr_addr;
  logic [READ_VALUE_W-1:0]  pend_value;
  logic                     pend_status;

  logic                     in_fire;
  logic                     out_free;
  logic [AW-1:0]            map_src;
  logic                     map_ok;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            waddr;
  logic [GENE_WIDTH-1:0]    wdata;
  logic                     single_we;
  logic                     we0, we1;
  logic [GENE_WIDTH-1:0]    rdata0, rdata1, rdata_cur;

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  pme_map #(.MAX_GENES(MAX_GENES)) u_map (
    .cmd (cmd),
    .idx (cnt[AW-1:0]),
    .src (map_src),
    .ok  (map_ok)
  );

  always_comb begin
    rdata_cur = bank ? rdata1 : rdata0;
    single_we = (state == S_DECODE) && map_ok && (cmd.op == OP_WRITE);
    rd_addr   = (state == S_COPY) ? map_src : AW'(cmd.first);
    waddr     = single_we ? AW'(cmd.first) : wr_addr;
    wdata     = single_we ? gene : rdata_cur;
    // single writes go to the active bank, the copy pass fills the other one
    we0       = (single_we && !bank) || (wr_pend && bank);
    we1       = (single_we && bank) || (wr_pend && !bank);
  end

  pme_ram #(.WIDTH(GENE_WIDTH), .DEPTH(MAX_GENES)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata0)
  );

  pme_ram #(.WIDTH(GENE_WIDTH), .DEPTH(MAX_GENES)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      bank       <= 1'b0;
      cnt        <= '0;
      wr_pend    <= 1'b0;
      m_tvalid   <= 1'b0;
      gene_count <= GENE_COUNT_RESET;
    end else begin
      if (cfg_wr_en) begin
        gene_count <= cfg_wr_data;
      end
      if (state == S_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      wr_pend <= (state == S_COPY) && (cnt != LAST);
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (!map_ok || cmd.op == OP_WRITE) begin
            state <= S_FIN;
          end else if (cmd.op == OP_READ) begin
            state <= S_READ;
          end else begin
            cnt   <= '0;
            state <= S_COPY;
          end
        end
        S_READ: begin
          state <= S_FIN;
        end
        S_COPY: begin
          if (cnt == LAST) begin
            // last write lands this cycle; hand over to the freshly filled bank
            bank  <= !bank;
            state <= S_FIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd.op      <= s_tdata[2:0];
      cmd.first   <= s_tdata[8:3];
      cmd.second  <= s_tdata[14:9];
      cmd.run_len <= s_tdata[20:15];
      cmd.count   <= gene_count;
      gene        <= GENE_WIDTH'(s_tdata[36:21]);
    end
    if (state == S_DECODE) begin
      pend_status <= !map_ok;
      pend_value  <= '0;
    end
    if (state == S_READ) begin
      pend_value <= READ_VALUE_W'(rdata_cur);
    end
    if (state == S_COPY) begin
      wr_addr <= cnt[AW-1:0];
    end
    if (state == S_FIN && out_free) begin
      m_tdata <= OUT_TDATA_W'({pend_status, pend_value});
    end
  end

  a_copy_in_pass: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> state == S_COPY)
    else $error("copy write outside the copy pass");

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(single_we && wr_pend))
    else $error("single write collides with copy write");

  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && bank != $past(bank)) |-> $past(state) == S_COPY)
    else $error("bank swapped outside the copy pass");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_FIN)
    else $error("result raised without a finished item");

endmodule
